[design/qspd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string pair decoder package
// Shared item types, character codes and the hex digit lookup.
// ----------------------------------------------------------------------------
package qspd_pkg;

  // Default segment store depth in bytes.
  localparam int SEGMENT_BYTES_DEF = 32;

  // Most result items emitted for one closed segment.
  localparam int RESULT_LIMIT = 32;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  // Character codes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_valid;
    logic       end_of_string;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_value;
    logic       last_of_pair;
    logic       truncated;
  } out_item_t;

  // Hex digit decode: bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end
    return d;
  endfunction

endpackage

[design/qspd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string pair decoder channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------

// Input item channel.
interface qspd_in_if;
  logic               valid;
  logic               ready;
  qspd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result item channel.
interface qspd_out_if;
  logic                valid;
  logic                ready;
  qspd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/query_string_pair_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string pair decoder
// Buffers '&'-separated segments and emits the raw key and decoded value.
// ----------------------------------------------------------------------------
// An input item is accepted whenever the decoder is idle. An item that
// closes a segment (an '&' or end_of_string) holds ready low while a small
// sequencer walks the segment store through its single read port: a close
// step, a read and a decode step per stored byte, then a flush, longer
// while the result side stalls. A segment with no '=' or an empty key or
// value goes from the close step back to idle. Each result is held back
// in a pending register so that the last of a pair can carry last_of_pair;
// the output register then holds it while the next item is accepted.
module query_string_pair_decoder #(
  parameter int SEGMENT_BYTES = qspd_pkg::SEGMENT_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  qspd_in_if.sink      in_chan,
  qspd_out_if.source   out_chan
);

  localparam int FILL_W = $clog2(SEGMENT_BYTES + 1);
  localparam int AW     = $clog2(SEGMENT_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_RD,
    ST_EV,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_HI,
    ESC_LO
  } esc_t;

  state_t                     state_r;
  esc_t                       esc_r;
  logic [FILL_W-1:0]          fill_r;
  logic [AW-1:0]              eq_r;
  logic                       eq_seen_r;
  logic                       ovf_r;
  logic [FILL_W-1:0]          j_r;
  logic [qspd_pkg::CNT_W-1:0] cnt_r;
  logic [4:0]                 hi_r;
  logic [7:0]                 rdata_r;
  logic                       pend_v_r;
  qspd_pkg::out_item_t        pend_r;
  logic                       out_valid_r;
  qspd_pkg::out_item_t        out_r;
  logic [7:0]                 mem [SEGMENT_BYTES];

  qspd_pkg::in_item_t in_item;
  logic               in_fire;
  logic               out_free;
  logic               is_amp;
  logic               do_store;
  logic               close_ok;

  // Decode of the byte read in the evaluate step.
  logic               prod;
  logic [7:0]         prod_byte;
  logic               prod_val;
  esc_t               esc_nxt;
  logic               stop;
  logic [4:0]         lo_digit;
  logic [FILL_W-1:0]  j_nxt;
  logic [FILL_W-1:0]  eq_ext;
  logic               stall;
  logic               cap_hit;

  // Next state of the output register.
  logic                out_valid_nxt;
  qspd_pkg::out_item_t out_nxt;

  assign in_item   = in_chan.payload;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire   = in_chan.valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign is_amp    = in_item.byte_valid && (in_item.in_byte == qspd_pkg::CH_AMP);
  assign do_store  = in_item.byte_valid && !is_amp
                     && (fill_r < FILL_W'(SEGMENT_BYTES));
  assign eq_ext    = FILL_W'(eq_r);
  assign close_ok  = eq_seen_r && (eq_r != '0)
                     && (({1'b0, eq_ext} + (FILL_W+1)'(1)) < {1'b0, fill_r});
  assign j_nxt     = j_r + FILL_W'(1);
  assign lo_digit  = qspd_pkg::hex_digit(rdata_r);

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  // Per-byte decode: key bytes raw, '=' skipped, value bytes unescaped.
  always_comb begin
    prod      = 1'b0;
    prod_byte = rdata_r;
    prod_val  = 1'b1;
    esc_nxt   = esc_r;
    stop      = (j_nxt == fill_r);
    if (j_r < eq_ext) begin
      prod     = 1'b1;
      prod_val = 1'b0;
    end else if (j_r != eq_ext) begin
      unique case (esc_r)
        ESC_HI: begin
          esc_nxt = ESC_LO;
        end
        ESC_LO: begin
          prod      = 1'b1;
          prod_byte = (hi_r[4] || lo_digit[4]) ? qspd_pkg::CH_DOT
                                                : {hi_r[3:0], lo_digit[3:0]};
          esc_nxt   = ESC_NONE;
        end
        default: begin
          if (rdata_r == qspd_pkg::CH_PLUS) begin
            prod      = 1'b1;
            prod_byte = qspd_pkg::CH_SPACE;
          end else if (rdata_r == qspd_pkg::CH_PCT) begin
            // A cut-short escape ends the value with nothing more emitted.
            if (({1'b0, j_r} + (FILL_W+1)'(2)) < {1'b0, fill_r}) begin
              esc_nxt = ESC_HI;
            end else begin
              stop = 1'b1;
            end
          end else begin
            prod = 1'b1;
          end
        end
      endcase
    end
  end

  assign stall   = prod && pend_v_r && !out_free;
  assign cap_hit = prod && (cnt_r + qspd_pkg::CNT_W'(1)
                            == qspd_pkg::CNT_W'(qspd_pkg::RESULT_LIMIT));

  // Output register: it takes the held-back result when that is passed on.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (state_r == ST_EV && !stall && prod && pend_v_r) begin
      out_nxt       = pend_r;
      out_valid_nxt = 1'b1;
    end else if (state_r == ST_FLUSH && pend_v_r && out_free) begin
      out_nxt              = pend_r;
      out_nxt.last_of_pair = 1'b1;
      out_valid_nxt        = 1'b1;
    end
  end

  // Segment store: written on accepted bytes, read by the sequencer.
  always_ff @(posedge clk) begin
    if (in_fire && do_store) begin
      mem[fill_r[AW-1:0]] <= in_item.in_byte;
    end
    if (state_r == ST_RD) begin
      rdata_r <= mem[j_r[AW-1:0]];
    end
  end

  // Sequencer, segment bookkeeping, held-back result and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      esc_r       <= ESC_NONE;
      fill_r      <= '0;
      eq_r        <= '0;
      eq_seen_r   <= 1'b0;
      ovf_r       <= 1'b0;
      j_r         <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (do_store) begin
              fill_r <= fill_r + FILL_W'(1);
              if (in_item.in_byte == qspd_pkg::CH_EQ) begin
                eq_r      <= fill_r[AW-1:0];
                eq_seen_r <= 1'b1;
              end
            end else if (in_item.byte_valid && !is_amp) begin
              ovf_r <= 1'b1;
            end
            if (is_amp || in_item.end_of_string) begin
              state_r <= ST_CLOSE;
            end
          end
        end
        ST_CLOSE: begin
          j_r   <= '0;
          cnt_r <= '0;
          esc_r <= ESC_NONE;
          if (close_ok) begin
            state_r <= ST_RD;
          end else begin
            fill_r    <= '0;
            eq_r      <= '0;
            eq_seen_r <= 1'b0;
            ovf_r     <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        ST_RD: begin
          state_r <= ST_EV;
        end
        ST_EV: begin
          if (!stall) begin
            esc_r <= esc_nxt;
            j_r   <= j_nxt;
            if (esc_r == ESC_HI) begin
              hi_r <= lo_digit;
            end
            if (prod) begin
              pend_v_r <= 1'b1;
              pend_r   <= '{out_byte: prod_byte, is_value: prod_val,
                            last_of_pair: 1'b0, truncated: ovf_r};
              cnt_r    <= cnt_r + qspd_pkg::CNT_W'(1);
            end
            state_r <= (stop || cap_hit) ? ST_FLUSH : ST_RD;
          end
        end
        ST_FLUSH: begin
          if (!pend_v_r || out_free) begin
            pend_v_r  <= 1'b0;
            fill_r    <= '0;
            eq_r      <= '0;
            eq_seen_r <= 1'b0;
            ovf_r     <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The input side only opens once the held-back result has been passed on.
  a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !pend_v_r)
    else $error("input ready while a result is still held back");

  // The store never counts more bytes than it holds.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(SEGMENT_BYTES))
    else $error("fill count beyond segment store depth");

  // A segment never emits more than the result limit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= qspd_pkg::CNT_W'(qspd_pkg::RESULT_LIMIT))
    else $error("result count beyond limit");

  // A scan that starts always has a key byte ahead of it.
  a_scan_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE && close_ok) |=> (state_r == ST_RD && eq_r != '0))
    else $error("segment scan started without a key");

endmodule

[tb/sv/query_string_pair_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string pair decoder testbench
// A short table of directed items, then random query strings, flows through
// the decoder under random idling on both channels. Result bytes are checked
// against a local model of the segment buffer and the URL value decoding.
// ----------------------------------------------------------------------------
module query_string_pair_decoder_tb;

  localparam int SEG_BYTES      = qspd_pkg::SEGMENT_BYTES_DEF;
  localparam int SEG_AW         = $clog2(SEG_BYTES);
  localparam int IN_W           = $bits(qspd_pkg::in_item_t);
  localparam int ITEM_BUDGET    = 255;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_CYCLES   = 3 * (3 + 2 * SEG_BYTES);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam qspd_pkg::out_item_t NO_OUT = '0;

  // One stimulus item; typed rows carry their expected results directly.
  typedef struct {
    qspd_pkg::in_item_t  item;
    bit                  typed;
    int                  n_exp;
    qspd_pkg::out_item_t exp [2];
  } stim_row_t;

  logic clk;
  logic rst_n;

  qspd_in_if  in_ch ();
  qspd_out_if out_ch ();

  query_string_pair_decoder #(
    .SEGMENT_BYTES (SEG_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Model state of the open segment.
  logic [7:0] seg_store [SEG_BYTES];
  logic [5:0] seg_fill    = '0;
  logic [5:0] seg_eq_pos  = '0;
  bit         seg_eq_seen = 1'b0;
  bit         seg_ovf     = 1'b0;

  qspd_pkg::out_item_t expected_bytes [$];
  stim_row_t           dir_table [$];
  int                  errors     = 0;
  int                  items_sent = 0;
  bit                  hold_req   = 1'b0;
  string               alnum_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.~";

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // Hex digit value; bit 4 set when the character is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b0, c[3:0]};
    end
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      return {1'b0, c[3:0] + 4'd9};
    end
    return 5'h10;
  endfunction

  function automatic qspd_pkg::out_item_t mk_out(input logic [7:0] b, input bit v,
                                                 input bit last, input bit trunc);
    qspd_pkg::out_item_t o;
    o.out_byte     = b;
    o.is_value     = v;
    o.last_of_pair = last;
    o.truncated    = trunc;
    return o;
  endfunction

  // Split the closed segment at its last '=' and emit key and decoded value.
  function automatic void close_segment(ref qspd_pkg::out_item_t res [$]);
    int unsigned fill;
    int unsigned eq;
    int unsigned j;
    int          start;
    logic [4:0]  h1;
    logic [4:0]  h2;
    logic [7:0]  c;
    start = res.size();
    fill  = seg_fill;
    eq    = seg_eq_pos;
    if (seg_eq_seen && eq > 0 && eq + 1 < fill) begin
      for (j = 0; j < eq; j++) begin
        res.push_back(mk_out(seg_store[SEG_AW'(j)], 1'b0, 1'b0, seg_ovf));
      end
      j = eq + 1;
      while (j < fill) begin
        c = seg_store[SEG_AW'(j)];
        if (c == qspd_pkg::CH_PLUS) begin
          res.push_back(mk_out(qspd_pkg::CH_SPACE, 1'b1, 1'b0, seg_ovf));
        end else if (c == qspd_pkg::CH_PCT) begin
          // An escape cut short by the segment end emits nothing.
          if (j + 2 < fill) begin
            h1 = hex_nibble(seg_store[SEG_AW'(j + 1)]);
            h2 = hex_nibble(seg_store[SEG_AW'(j + 2)]);
            if (!h1[4] && !h2[4]) begin
              res.push_back(mk_out({h1[3:0], h2[3:0]}, 1'b1, 1'b0, seg_ovf));
            end else begin
              res.push_back(mk_out(qspd_pkg::CH_DOT, 1'b1, 1'b0, seg_ovf));
            end
          end
          j += 2;
        end else begin
          res.push_back(mk_out(c, 1'b1, 1'b0, seg_ovf));
        end
        j++;
      end
      if (res.size() > start) begin
        res[res.size() - 1].last_of_pair = 1'b1;
      end
    end
    seg_fill    = '0;
    seg_eq_pos  = '0;
    seg_eq_seen = 1'b0;
    seg_ovf     = 1'b0;
  endfunction

  // Advance the model by one accepted item.
  function automatic void decode_item(input qspd_pkg::in_item_t it,
                                      ref qspd_pkg::out_item_t res [$]);
    if (it.byte_valid) begin
      if (it.in_byte == qspd_pkg::CH_AMP) begin
        close_segment(res);
      end else if (int'(seg_fill) < SEG_BYTES) begin
        seg_store[seg_fill[SEG_AW-1:0]] = it.in_byte;
        if (it.in_byte == qspd_pkg::CH_EQ) begin
          seg_eq_pos  = seg_fill;
          seg_eq_seen = 1'b1;
        end
        seg_fill++;
      end else begin
        seg_ovf = 1'b1;
      end
    end
    if (it.end_of_string) begin
      close_segment(res);
    end
  endfunction

  function automatic void apply_row(input stim_row_t r);
    qspd_pkg::out_item_t res [$];
    decode_item(r.item, res);
    if (r.typed) begin
      for (int i = 0; i < r.n_exp; i++) begin
        expected_bytes.push_back(r.exp[i]);
      end
    end else begin
      foreach (res[i]) begin
        expected_bytes.push_back(res[i]);
      end
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic qspd_pkg::in_item_t mk_item(input logic [7:0] b, input bit v,
                                                 input bit e);
    qspd_pkg::in_item_t it;
    it.in_byte       = b;
    it.byte_valid    = v;
    it.end_of_string = e;
    return it;
  endfunction

  function automatic stim_row_t plain_row(input qspd_pkg::in_item_t it);
    stim_row_t r;
    r.item   = it;
    r.typed  = 1'b0;
    r.n_exp  = 0;
    r.exp[0] = NO_OUT;
    r.exp[1] = NO_OUT;
    return r;
  endfunction

  function automatic void dir_row(input logic [7:0] b, input bit v, input bit e);
    dir_table.push_back(plain_row(mk_item(b, v, e)));
  endfunction

  function automatic void dir_typed(input logic [7:0] b, input bit v, input bit e,
                                    input int n, input qspd_pkg::out_item_t o0,
                                    input qspd_pkg::out_item_t o1);
    stim_row_t r;
    r        = plain_row(mk_item(b, v, e));
    r.typed  = 1'b1;
    r.n_exp  = n;
    r.exp[0] = o0;
    r.exp[1] = o1;
    dir_table.push_back(r);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] any_but_amp();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == qspd_pkg::CH_AMP);
    return c;
  endfunction

  function automatic logic [7:0] word_char();
    return alnum_chars[$urandom_range(0, alnum_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] hex_char();
    logic [3:0] d;
    d = 4'($urandom_range(0, 15));
    if (d < 10) begin
      return 8'h30 + 8'(d);
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d - 10);
  endfunction

  function automatic void push_value_token(ref qspd_pkg::in_item_t seg [$]);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      seg.push_back(mk_item(word_char(), 1'b1, 1'b0));
    end else if (r < 55) begin
      seg.push_back(mk_item(qspd_pkg::CH_PLUS, 1'b1, 1'b0));
    end else if (r < 75) begin
      seg.push_back(mk_item(qspd_pkg::CH_PCT, 1'b1, 1'b0));
      seg.push_back(mk_item(hex_char(), 1'b1, 1'b0));
      seg.push_back(mk_item(hex_char(), 1'b1, 1'b0));
    end else if (r < 82) begin
      // Escape with at least one digit that is not hex.
      seg.push_back(mk_item(qspd_pkg::CH_PCT, 1'b1, 1'b0));
      seg.push_back(mk_item($urandom_range(0, 1) ? word_char() : hex_char(), 1'b1, 1'b0));
      seg.push_back(mk_item("g" + 8'($urandom_range(0, 19)), 1'b1, 1'b0));
    end else begin
      seg.push_back(mk_item(any_but_amp(), 1'b1, 1'b0));
    end
  endfunction

  // Offer one item after an optional gap and wait until it is taken.
  task automatic send_item(input stim_row_t r, input int gap);
    if (gap > 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= r.item;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_row(r);
    items_sent++;
  endtask

  // Build one random key=value segment with its terminator and send it.
  task automatic send_segment(input bit force_long);
    qspd_pkg::in_item_t seg [$];
    int       kind;
    int       klen;
    int       vlen;
    int       term;
    bit       steady;
    kind = force_long ? 5 : $urandom_range(0, 99);
    klen = $urandom_range(1, 6);
    vlen = $urandom_range(1, 8);
    if (kind < 3) begin
      // The '=' itself falls past the end of the store.
      klen = SEG_BYTES + $urandom_range(0, 4);
    end else if (kind < 8) begin
      klen = $urandom_range(1, 12);
      vlen = SEG_BYTES + $urandom_range(0, 12);
    end else if (kind < 14) begin
      klen = 0;
    end else if (kind < 20) begin
      vlen = 0;
    end
    for (int i = 0; i < klen; i++) begin
      seg.push_back(mk_item(($urandom_range(0, 4) == 0) ? any_but_amp() : word_char(),
                            1'b1, 1'b0));
    end
    // Segments without any '=' for one kind.
    if (kind < 20 || kind >= 26) begin
      seg.push_back(mk_item(qspd_pkg::CH_EQ, 1'b1, 1'b0));
    end
    for (int i = 0; i < vlen; i++) begin
      push_value_token(seg);
    end
    // Now and then an escape cut short by the segment end.
    if ($urandom_range(0, 9) == 0) begin
      seg.push_back(mk_item(qspd_pkg::CH_PCT, 1'b1, 1'b0));
      if ($urandom_range(0, 1) == 1) begin
        seg.push_back(mk_item(hex_char(), 1'b1, 1'b0));
      end
    end
    term = $urandom_range(0, 99);
    if (term < 60) begin
      seg.push_back(mk_item(qspd_pkg::CH_AMP, 1'b1, 1'b0));
    end else if (term < 75) begin
      if (seg.size() == 0) begin
        seg.push_back(mk_item(8'($urandom), 1'b0, 1'b1));
      end else begin
        seg[seg.size() - 1].end_of_string = 1'b1;
      end
    end else if (term < 85) begin
      seg.push_back(mk_item(8'($urandom), 1'b0, 1'b1));
    end else if (term < 95) begin
      seg.push_back(mk_item(qspd_pkg::CH_AMP, 1'b1, 1'b1));
    end
    // Otherwise the segment runs on into the next one.
    steady = ($urandom_range(0, 3) == 0);
    foreach (seg[i]) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(plain_row(mk_item(8'($urandom), 1'b0, 1'b0)), pick_gap());
      end
      send_item(plain_row(seg[i]), steady ? 0 : pick_gap());
    end
  endtask

  // Main sequence: reset, directed table, random strings, drain.
  initial begin : stimulus
    bit paused;
    paused        = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;

    // Plain pair right after reset.
    dir_row("a", 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_EQ, 1'b1, 1'b0);
    dir_typed("b", 1'b1, 1'b1, 2, mk_out("a", 0, 0, 0), mk_out("b", 1, 1, 0));
    // Empty key.
    dir_row(qspd_pkg::CH_EQ, 1'b1, 1'b0);
    dir_row("x", 1'b1, 1'b0);
    dir_typed(qspd_pkg::CH_AMP, 1'b1, 1'b0, 0, NO_OUT, NO_OUT);
    // Empty value.
    dir_row("k", 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_EQ, 1'b1, 1'b0);
    dir_typed(qspd_pkg::CH_AMP, 1'b1, 1'b0, 0, NO_OUT, NO_OUT);
    // Top byte as key, escape with a bad hex digit.
    dir_row(8'hFF, 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_EQ, 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_PCT, 1'b1, 1'b0);
    dir_row("g", 1'b1, 1'b0);
    dir_row("1", 1'b1, 1'b0);
    dir_typed(qspd_pkg::CH_AMP, 1'b1, 1'b0, 2, mk_out(8'hFF, 0, 0, 0),
              mk_out(qspd_pkg::CH_DOT, 1, 1, 0));
    // Escape cut short, value decodes to nothing, ampersand with end of string.
    dir_row("n", 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_EQ, 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_PCT, 1'b1, 1'b0);
    dir_row("4", 1'b1, 1'b0);
    dir_typed(qspd_pkg::CH_AMP, 1'b1, 1'b1, 1, mk_out("n", 0, 1, 0), NO_OUT);
    // Invalid item changes nothing.
    dir_typed(8'h00, 1'b0, 1'b0, 0, NO_OUT, NO_OUT);
    // Zero byte as key, plus and a good escape in the value.
    dir_row(8'h00, 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_EQ, 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_PLUS, 1'b1, 1'b0);
    dir_row(qspd_pkg::CH_PCT, 1'b1, 1'b0);
    dir_row("4", 1'b1, 1'b0);
    dir_row("a", 1'b1, 1'b1);
    // No equals sign, closed by an end marker alone.
    dir_row("z", 1'b1, 1'b0);
    dir_typed(8'hFF, 1'b0, 1'b1, 0, NO_OUT, NO_OUT);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      send_item(dir_table[i], pick_gap());
    end

    // The result side holds off for a while as the random part begins.
    hold_req = 1'b1;
    send_segment(1'b1);
    while (items_sent < ITEM_BUDGET) begin
      if (!paused && items_sent >= ITEM_BUDGET / 2) begin
        // Let the decoder run dry before going on.
        paused      = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
      end
      send_segment(1'b0);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side ready pattern, with one long hold-off on request.
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Compare each result item with the oldest expected byte.
  always @(posedge clk) begin
    qspd_pkg::out_item_t want;
    qspd_pkg::out_item_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.payload;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: byte=%h value=%b last=%b trunc=%b",
                 $time, got.out_byte, got.is_value, got.last_of_pair, got.truncated);
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.is_value !== want.is_value ||
            got.last_of_pair !== want.last_of_pair || got.truncated !== want.truncated) begin
          errors++;
          $display("%0t: mismatch: expected byte=%h value=%b last=%b trunc=%b, %s",
                   $time, want.out_byte, want.is_value, want.last_of_pair,
                   want.truncated,
                   $sformatf("actual byte=%h value=%b last=%b trunc=%b",
                             got.out_byte, got.is_value, got.last_of_pair,
                             got.truncated));
        end
      end
    end
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    int stall_cycles;
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
